@@ sv/gbfd_pkg.sv @@
// Shared types and constants of the GNSS binary frame decoder.
package gbfd_pkg;

  // Frame parse phases
  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LENLO,
    PH_LENHI,
    PH_PAYLOAD,
    PH_CKA,
    PH_CKB
  } phase_t;

  // Message kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ESF  = 2'd1;
  localparam logic [1:0] KIND_POS  = 2'd2;
  localparam logic [1:0] KIND_VEL  = 2'd3;

  // Result kinds
  localparam logic [1:0] RES_SENSOR    = 2'd0;
  localparam logic [1:0] RES_NAV       = 2'd1;
  localparam logic [1:0] RES_FRAME_END = 2'd2;

  // Protocol bytes
  localparam logic [7:0] SYNC_CHAR1 = 8'hB5;
  localparam logic [7:0] SYNC_CHAR2 = 8'h62;
  localparam logic [7:0] CLASS_ESF  = 8'h10;
  localparam logic [7:0] ID_ESF_RAW = 8'h03;
  localparam logic [7:0] CLASS_NAV  = 8'h01;
  localparam logic [7:0] ID_POSECEF = 8'h01;
  localparam logic [7:0] ID_VELECEF = 8'h11;

  // Payload layout
  localparam logic [13:0] NAV_FIELDS   = 14'd5;
  localparam logic [2:0]  ESF_RESERVED = 3'd4;

  // Sensor data types that count as recognized
  localparam logic [7:0] TYPE_GYRO_Z  = 8'd5;
  localparam logic [7:0] TYPE_TEMP    = 8'd12;
  localparam logic [7:0] TYPE_GYRO_Y  = 8'd13;
  localparam logic [7:0] TYPE_GYRO_X  = 8'd14;
  localparam logic [7:0] TYPE_ACCEL_X = 8'd16;
  localparam logic [7:0] TYPE_ACCEL_Y = 8'd17;
  localparam logic [7:0] TYPE_ACCEL_Z = 8'd18;

  // One result beat
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  message_kind;
    logic [7:0]  item_code;
    logic [31:0] field_value;
    logic [31:0] time_tag;
    logic        type_recognized;
    logic        checksum_ok;
  } result_t;

endpackage

@@ sv/gbfd_if.sv @@
// Stream interfaces: raw byte channel and decoded result channel.
interface gbfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface gbfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [1:0]  message_kind;
  logic [7:0]  item_code;
  logic [31:0] field_value;
  logic [31:0] time_tag;
  logic        type_recognized;
  logic        checksum_ok;

  modport source (
    output valid, output result_kind, output message_kind, output item_code,
    output field_value, output time_tag, output type_recognized,
    output checksum_ok, input ready
  );
  modport sink (
    input valid, input result_kind, input message_kind, input item_code,
    input field_value, input time_tag, input type_recognized,
    input checksum_ok, output ready
  );
endinterface

@@ sv/gnss_binary_frame_decoder.sv @@
// GNSS binary frame decoder: one stream byte per cycle in, at most one result per byte out.
// Takes one byte per clock cycle with no gaps needed between frames; each accepted byte updates
// the parser state; any result it causes is registered into the output register, or into the
// skid slot while the register is full. The two-entry buffer lets the byte side keep taking beats
// while a result waits; the byte side stalls only when both entries are full. Sensor raw frames
// give one result per 8-byte measurement, position and velocity ECEF frames one per 4-byte
// field (first five), and every frame ends with a result carrying the message kind and the
// checksum verdict. Values are raw receiver words, sensor values sign-extended from 24 bits.
module gnss_binary_frame_decoder (
  input logic         clk,
  input logic         rst,
  gbfd_byte_if.sink   stream,
  gbfd_result_if.source result
);
  import gbfd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    can_push;
  result_t dout;

  assign stream.ready = can_push;
  assign accept       = stream.valid && can_push;

  gbfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (stream.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  gbfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .din       (res),
    .can_push  (can_push),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .dout      (dout)
  );

  // Result beat fields
  assign result.result_kind     = dout.result_kind;
  assign result.message_kind    = dout.message_kind;
  assign result.item_code       = dout.item_code;
  assign result.field_value     = dout.field_value;
  assign result.time_tag        = dout.time_tag;
  assign result.type_recognized = dout.type_recognized;
  assign result.checksum_ok     = dout.checksum_ok;

endmodule

@@ sv/gbfd_parser.sv @@
// Frame parser: sync search, header decode, checksum and field extraction.
module gbfd_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  output logic                   res_valid,
  output gbfd_pkg::result_t      res
);
  import gbfd_pkg::*;

  phase_t       phase, phase_next;
  logic [1:0]   frame_kind, frame_kind_next;
  logic [7:0]   class_byte, class_byte_next;
  logic [15:0]  payload_length, payload_length_next;
  logic [15:0]  byte_count, byte_count_next;
  logic [7:0]   sum_a, sum_a_next;
  logic [7:0]   sum_b, sum_b_next;
  logic [7:0]   received_sum_a, received_sum_a_next;
  logic [31:0]  field_shift, field_shift_next;
  logic [23:0]  held_value, held_value_next;
  logic [7:0]   held_type, held_type_next;

  logic [7:0]   add_a;
  logic [7:0]   add_b;
  logic [15:0]  count_inc;
  logic [15:0]  length_full;
  logic [31:0]  shift_in;
  logic [2:0]   esf_pos;
  logic         esf_body;
  logic         type_known;

  // Running Fletcher sums and shared payload terms
  assign add_a       = sum_a + data_byte;
  assign add_b       = sum_b + add_a;
  assign count_inc   = byte_count + 16'd1;
  assign length_full = {data_byte, payload_length[7:0]};
  assign shift_in    = {data_byte, field_shift[31:8]};
  assign esf_pos     = byte_count[2:0] - ESF_RESERVED;
  assign esf_body    = |byte_count[15:2];

  always_comb begin
    type_known = (held_type == TYPE_GYRO_Z) || (held_type == TYPE_TEMP) ||
                 (held_type == TYPE_GYRO_Y) || (held_type == TYPE_GYRO_X) ||
                 (held_type == TYPE_ACCEL_X) || (held_type == TYPE_ACCEL_Y) ||
                 (held_type == TYPE_ACCEL_Z);
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SYNC1: if (data_byte == SYNC_CHAR1) phase_next = PH_SYNC2;
      PH_SYNC2: begin
        if (data_byte == SYNC_CHAR2) phase_next = PH_CLASS;
        else if (data_byte != SYNC_CHAR1) phase_next = PH_SYNC1;
      end
      PH_CLASS: phase_next = PH_ID;
      PH_ID:    phase_next = PH_LENLO;
      PH_LENLO: phase_next = PH_LENHI;
      PH_LENHI: phase_next = (length_full == 16'd0) ? PH_CKA : PH_PAYLOAD;
      PH_PAYLOAD: if (count_inc >= payload_length) phase_next = PH_CKA;
      PH_CKA:   phase_next = PH_CKB;
      PH_CKB:   phase_next = PH_SYNC1;
      default:  phase_next = PH_SYNC1;
    endcase
  end

  // Datapath updates and result
  always_comb begin
    frame_kind_next     = frame_kind;
    class_byte_next     = class_byte;
    payload_length_next = payload_length;
    byte_count_next     = byte_count;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    received_sum_a_next = received_sum_a;
    field_shift_next    = field_shift;
    held_value_next     = held_value;
    held_type_next      = held_type;
    res_valid           = 1'b0;
    res                 = '0;
    case (phase)
      PH_SYNC2: begin
        if (data_byte == SYNC_CHAR2) begin
          sum_a_next = 8'd0;
          sum_b_next = 8'd0;
        end
      end
      PH_CLASS: begin
        sum_a_next      = add_a;
        sum_b_next      = add_b;
        class_byte_next = data_byte;
      end
      PH_ID: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        if (class_byte == CLASS_ESF && data_byte == ID_ESF_RAW)
          frame_kind_next = KIND_ESF;
        else if (class_byte == CLASS_NAV && data_byte == ID_POSECEF)
          frame_kind_next = KIND_POS;
        else if (class_byte == CLASS_NAV && data_byte == ID_VELECEF)
          frame_kind_next = KIND_VEL;
        else
          frame_kind_next = KIND_NONE;
      end
      PH_LENLO: begin
        sum_a_next          = add_a;
        sum_b_next          = add_b;
        payload_length_next = {8'd0, data_byte};
      end
      PH_LENHI: begin
        sum_a_next          = add_a;
        sum_b_next          = add_b;
        payload_length_next = length_full;
        byte_count_next     = 16'd0;
        field_shift_next    = 32'd0;
      end
      PH_PAYLOAD: begin
        sum_a_next       = add_a;
        sum_b_next       = add_b;
        field_shift_next = shift_in;
        byte_count_next  = count_inc;
        if (frame_kind == KIND_ESF) begin
          if (esf_body) begin
            case (esf_pos)
              3'd0: held_value_next[7:0]   = data_byte;
              3'd1: held_value_next[15:8]  = data_byte;
              3'd2: held_value_next[23:16] = data_byte;
              3'd3: held_type_next         = data_byte;
              3'd7: begin
                res_valid           = 1'b1;
                res.result_kind     = RES_SENSOR;
                res.message_kind    = KIND_ESF;
                res.item_code       = held_type;
                res.field_value     = {{8{held_value[23]}}, held_value};
                res.time_tag        = shift_in;
                res.type_recognized = type_known;
              end
              default: ;
            endcase
          end
        end else if (frame_kind == KIND_POS || frame_kind == KIND_VEL) begin
          // one field per 4 bytes, first five fields only
          if (byte_count[1:0] == 2'd3 && byte_count[15:2] < NAV_FIELDS) begin
            res_valid        = 1'b1;
            res.result_kind  = RES_NAV;
            res.message_kind = frame_kind;
            res.item_code    = {5'd0, byte_count[4:2]};
            res.field_value  = shift_in;
          end
        end
      end
      PH_CKA: received_sum_a_next = data_byte;
      PH_CKB: begin
        res_valid        = 1'b1;
        res.result_kind  = RES_FRAME_END;
        res.message_kind = frame_kind;
        res.checksum_ok  = (received_sum_a == sum_a) && (data_byte == sum_b);
      end
      default: ;
    endcase
  end

  // State registers, advanced once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      frame_kind     <= KIND_NONE;
      class_byte     <= '0;
      payload_length <= '0;
      byte_count     <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      received_sum_a <= '0;
      field_shift    <= '0;
      held_value     <= '0;
      held_type      <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      frame_kind     <= frame_kind_next;
      class_byte     <= class_byte_next;
      payload_length <= payload_length_next;
      byte_count     <= byte_count_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      received_sum_a <= received_sum_a_next;
      field_shift    <= field_shift_next;
      held_value     <= held_value_next;
      held_type      <= held_type_next;
    end
  end

endmodule

@@ sv/gbfd_out_buf.sv @@
// Two-entry output buffer: result register plus skid slot.
module gbfd_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  gbfd_pkg::result_t      din,
  output logic                   can_push,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gbfd_pkg::result_t      dout
);
  import gbfd_pkg::*;

  result_t main, main_next;
  result_t skid, skid_next;
  logic    main_valid, main_valid_next;
  logic    skid_valid, skid_valid_next;
  logic    pop;

  assign pop       = main_valid && out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign dout      = main;

  // Slot movement
  always_comb begin
    main_next       = main;
    skid_next       = skid;
    main_valid_next = main_valid;
    skid_valid_next = skid_valid;
    if (pop) begin
      if (skid_valid) begin
        main_next       = skid;
        skid_valid_next = 1'b0;
      end else begin
        main_next       = din;
        main_valid_next = push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_next       = din;
        main_valid_next = 1'b1;
      end else begin
        skid_next       = din;
        skid_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    main <= main_next;
    skid <= skid_next;
  end

endmodule
